// ----- sv/jkve_pkg.sv -----
`default_nettype none
package jkve_pkg;

  // scan phases
  localparam logic [2:0] PH_SEEK     = 3'd0;
  localparam logic [2:0] PH_TOKEN    = 3'd1;
  localparam logic [2:0] PH_AFTER    = 3'd2;
  localparam logic [2:0] PH_VALWS    = 3'd3;
  localparam logic [2:0] PH_NUMSTART = 3'd4;
  localparam logic [2:0] PH_DIGITS   = 3'd5;
  localparam logic [2:0] PH_BOOL     = 3'd6;
  localparam logic [2:0] PH_DONE     = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // query kinds
  localparam logic [1:0] QK_PRESENCE = 2'd0;
  localparam logic [1:0] QK_SIGNED   = 2'd1;
  localparam logic [1:0] QK_UNSIGNED = 2'd2;
  localparam logic [1:0] QK_BOOL     = 2'd3;

  // register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [1:0] REG_KIND     = 2'd3;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [35:0] U32_MAX     = 36'hFFFF_FFFF;
  localparam logic [31:0] S32_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MINM  = 32'h8000_0000;  // magnitude of the most negative int32
  localparam logic [4:0]  TOKEN_SAT   = 5'd31;
  localparam logic [2:0]  BOOL_T_REST = 3'd3;
  localparam logic [2:0]  BOOL_F_REST = 3'd4;

  localparam int KEY_MAX_BYTES_DEF = 16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  count;
    logic        mismatch;
    logic        negative;
    logic [31:0] acc;
    logic [2:0]  bool_rem;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [32:0] value;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // judge a completed number under the current query kind
  function automatic result_t finish_number(input logic [31:0] v, input logic neg,
                                            input logic [1:0] kind);
    result_t r;
    r.status = ST_OK;
    r.value  = 33'sd0;
    if (kind == QK_SIGNED) begin
      if (neg) begin
        if (v > INT32_MINM) r.status = ST_RANGE;
        else r.value = 33'sd0 - $signed({1'b0, v});
      end else begin
        if (v > S32_POS_MAX) r.status = ST_RANGE;
        else r.value = $signed({1'b0, v});
      end
    end else begin
      if (neg && (v != 32'd0)) r.status = ST_RANGE;
      else r.value = $signed({1'b0, v});
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/json_key_value_extractor.sv -----
`default_nettype none
// JSON key/value extractor. Feed one byte of a flat JSON text per transaction on the
// in_ channel, with in_tlast on the final byte of each buffer. The block finds the first
// quoted token equal to the configured key (key_bytes_low/high, key_length, clamped to
// KEY_MAX_BYTES) that is followed by a colon, then reads the value as query_kind asks:
// presence, signed int32, unsigned uint32 or boolean. Exactly one result transaction leaves
// on the out_ channel per buffer, either as soon as the value is decided or on the last byte;
// bytes after a decision are swallowed until in_tlast. The result carries a status
// (ok, key absent, malformed, out of range) and a 33-bit signed value (zero unless ok).
// Throughput is one byte per clock until the skid register fills: the whole scan update for
// a byte is a single pass of combinational logic from the state registers, whose deepest
// path is the multiply-by-ten add and range compare of the number accumulator. A result is
// registered in a two-entry output buffer (result register plus skid register for stalls).
// Configuration must be written by the user over the APB-style port at byte addresses 0, 8,
// 16 and 24, only while the block is idle; the block itself does not enforce this.
module json_key_value_extractor #(
  parameter int KEY_MAX_BYTES = jkve_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] text_byte
  input  logic        in_tlast,     // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [1:0] query_status, [34:2] value, [39:35] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import jkve_pkg::*;

  // configuration registers
  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [4:0]  key_len_r;
  logic [1:0]  kind_r;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // scan state
  scan_state_t st_r, st_nxt;
  logic        emit;
  result_t     res;
  logic        in_acc;

  // output buffer
  logic        out_valid_r;
  result_t     out_res_r;
  logic        skid_valid_r;
  result_t     skid_res_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= 64'd0;
      key_high_r <= 64'd0;
      key_len_r  <= 5'd0;
      kind_r     <= QK_PRESENCE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_LOW:  key_low_r  <= cfg_pwdata;
        REG_KEY_HIGH: key_high_r <= cfg_pwdata;
        REG_KEY_LEN:  key_len_r  <= cfg_pwdata[4:0];
        REG_KIND:     kind_r     <= cfg_pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    case (cfg_idx)
      REG_KEY_LOW:  cfg_prdata = key_low_r;
      REG_KEY_HIGH: cfg_prdata = key_high_r;
      REG_KEY_LEN:  cfg_prdata = {59'd0, key_len_r};
      REG_KIND:     cfg_prdata = {62'd0, kind_r};
      default:      cfg_prdata = 64'd0;
    endcase
  end

  // one byte per cycle through the scan logic, unless the input is stalled
  jkve_scan #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_scan (
    .st        (st_r),
    .text_byte (in_tdata),
    .last_byte (in_tlast),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .key_length(key_len_r),
    .query_kind(kind_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res)
  );

  // stall the input only once the skid register is occupied
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_SEEK, count: 5'd0, mismatch: 1'b0, negative: 1'b0,
                acc: 32'd0, bool_rem: 3'd0};
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register plus skid: a new result goes straight out when the output
  // register is free or draining, else parks in the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_tready) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc && emit) begin
        if (!out_valid_r || out_tready) out_valid_r <= 1'b1;
        else skid_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) out_res_r <= skid_res_r;
    end else if (in_acc && emit) begin
      if (!out_valid_r || out_tready) out_res_r <= res;
      else skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.value, out_res_r.status};

`ifndef SYNTH
  // the skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  // a finished buffer always restarts the scan
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (st_r.phase == PH_SEEK))
    else $error("scan not restarted after last byte");

  // at most one result per buffer: nothing is emitted once decided
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (st_r.phase == PH_DONE)) |-> !emit)
    else $error("second result emitted within one buffer");

  // the accumulator holds at most a 32-bit magnitude and zero after a restart
  a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> ((st_r.acc == 32'd0) && (st_r.count == 5'd0)))
    else $error("scan state not cleared at buffer end");
`endif

endmodule
`default_nettype wire

// ----- sv/jkve_scan.sv -----
`default_nettype none
module jkve_scan #(
  parameter int KEY_MAX_BYTES = jkve_pkg::KEY_MAX_BYTES_DEF
) (
  input  jkve_pkg::scan_state_t st,
  input  logic [7:0]            text_byte,
  input  logic                  last_byte,
  input  logic [63:0]           key_low,
  input  logic [63:0]           key_high,
  input  logic [4:0]            key_length,
  input  logic [1:0]            query_kind,
  output jkve_pkg::scan_state_t st_nxt,
  output logic                  emit,
  output jkve_pkg::result_t     res
);
  import jkve_pkg::*;

  localparam logic [4:0] KMAX = 5'(KEY_MAX_BYTES);
  localparam int         IDXW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  logic [127:0]  key_all;
  logic [7:0]    key_arr [KEY_MAX_BYTES];
  logic [4:0]    klen;
  logic [7:0]    digit;
  logic [35:0]   prod;
  logic [2:0]    rem_dec;
  logic          char_bad;

  assign key_all = {key_high, key_low};
  assign klen    = (key_length > KMAX) ? KMAX : key_length;
  assign digit   = text_byte - CH_ZERO;
  assign prod    = ({4'd0, st.acc} << 3) + ({4'd0, st.acc} << 1) + {28'd0, digit};
  assign rem_dec = (st.bool_rem != 3'd0) ? st.bool_rem - 3'd1 : 3'd0;

  for (genvar g = 0; g < KEY_MAX_BYTES; g++) begin : g_key
    assign key_arr[g] = key_all[g*8 +: 8];
  end

  // count below klen keeps the index inside the key
  assign char_bad = (st.count >= klen) ? 1'b1 : (text_byte != key_arr[st.count[IDXW-1:0]]);

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '{status: ST_OK, value: 33'sd0};

    case (st.phase)
      PH_SEEK: begin
        if (text_byte == CH_QUOTE) begin
          st_nxt.phase    = PH_TOKEN;
          st_nxt.count    = 5'd0;
          st_nxt.mismatch = 1'b0;
        end
      end
      PH_TOKEN: begin
        if (text_byte == CH_QUOTE) begin
          st_nxt.mismatch = st.mismatch | (st.count != klen);
          st_nxt.phase    = PH_AFTER;
        end else begin
          if (char_bad) st_nxt.mismatch = 1'b1;
          if (st.count < TOKEN_SAT) st_nxt.count = st.count + 5'd1;
        end
      end
      PH_AFTER: begin
        if (!is_space(text_byte)) begin
          if (text_byte == CH_COLON) begin
            st_nxt.phase = st.mismatch ? PH_SEEK : PH_VALWS;
          end else if (text_byte == CH_QUOTE) begin
            st_nxt.phase    = PH_TOKEN;
            st_nxt.count    = 5'd0;
            st_nxt.mismatch = 1'b0;
          end else begin
            st_nxt.phase = PH_SEEK;
          end
        end
      end
      PH_VALWS: begin
        if (!is_space(text_byte)) begin
          st_nxt.acc      = 32'd0;
          st_nxt.negative = 1'b0;
          case (query_kind)
            QK_PRESENCE: begin
              emit = 1'b1;
            end
            QK_BOOL: begin
              if (text_byte == CH_T) begin
                st_nxt.acc      = 32'd1;
                st_nxt.bool_rem = BOOL_T_REST;
                st_nxt.phase    = PH_BOOL;
              end else if (text_byte == CH_F) begin
                st_nxt.bool_rem = BOOL_F_REST;
                st_nxt.phase    = PH_BOOL;
              end else begin
                emit       = 1'b1;
                res.status = ST_MALFORMED;
              end
            end
            default: begin
              if (text_byte == CH_MINUS) begin
                st_nxt.negative = 1'b1;
                st_nxt.phase    = PH_NUMSTART;
              end else if (is_digit(text_byte)) begin
                st_nxt.acc   = {24'd0, digit};
                st_nxt.phase = PH_DIGITS;
              end else begin
                emit       = 1'b1;
                res.status = ST_MALFORMED;
              end
            end
          endcase
        end
      end
      PH_NUMSTART: begin
        if (is_digit(text_byte)) begin
          st_nxt.acc   = {24'd0, digit};
          st_nxt.phase = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          res.status = ST_MALFORMED;
        end
      end
      PH_DIGITS: begin
        if (is_digit(text_byte)) begin
          if (prod > U32_MAX) begin
            emit       = 1'b1;
            res.status = ST_RANGE;
          end else begin
            st_nxt.acc = prod[31:0];
          end
        end else begin
          emit = 1'b1;
          res  = finish_number(st.acc, st.negative, query_kind);
        end
      end
      PH_BOOL: begin
        st_nxt.bool_rem = rem_dec;
        if (rem_dec == 3'd0) begin
          emit      = 1'b1;
          res.value = $signed({1'b0, st.acc});
        end
      end
      PH_DONE: begin
      end
      default: begin
        st_nxt.phase = PH_SEEK;
      end
    endcase

    if (emit) st_nxt.phase = PH_DONE;

    // end of buffer: force a result if none yet, then start afresh
    if (last_byte) begin
      if (!emit && (st_nxt.phase != PH_DONE)) begin
        emit = 1'b1;
        if (st_nxt.phase == PH_DIGITS) begin
          res = finish_number(st_nxt.acc, st_nxt.negative, query_kind);
        end else if ((st_nxt.phase == PH_NUMSTART) || (st_nxt.phase == PH_BOOL)) begin
          res.status = ST_MALFORMED;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      st_nxt.phase    = PH_SEEK;
      st_nxt.count    = 5'd0;
      st_nxt.mismatch = 1'b0;
      st_nxt.negative = 1'b0;
      st_nxt.acc      = 32'd0;
      st_nxt.bool_rem = 3'd0;
    end
  end

endmodule
`default_nettype wire
